>>> rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sct_pkg.sv
package sct_pkg;

   // widths
   localparam int unsigned CODE_W  = 8;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned JOB_MAX = 4;
   localparam int unsigned IDX_W   = $clog2(JOB_MAX);

   // job queue between decoder and serializer
   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

   // marker and mask values
   localparam logic [7:0] PREFIX_E0 = 8'hE0;
   localparam logic [7:0] NOMAP     = 8'h80;
   localparam logic [7:0] CTL_MASK  = 8'h1F;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_O      = 8'h4F;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] TBL_LEN   = 8'd84;

   // function key codes
   localparam logic [7:0] SC_F1       = 8'd59;
   localparam logic [7:0] SC_F9       = 8'd67;
   localparam logic [7:0] SC_F10      = 8'd68;
   localparam logic [7:0] SC_F11      = 8'd87;
   localparam logic [7:0] SC_F12      = 8'd88;
   // offset from F1 code to 'P'
   localparam logic [7:0] FKEY_TO_CH  = 8'd21;

   // modifier codes
   localparam logic [7:0] SC_LSHIFT    = 8'h2A;
   localparam logic [7:0] SC_RSHIFT    = 8'h36;
   localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
   localparam logic [7:0] SC_CTRL      = 8'h1D;
   localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
   localparam logic [7:0] SC_ALT       = 8'h38;
   localparam logic [7:0] SC_ALT_UP    = 8'hB8;
   localparam logic [7:0] SC_CAPS      = 8'h3A;
   localparam logic [7:0] SC_NUM       = 8'h45;
   localparam logic [7:0] SC_CAPS_UP   = 8'hBA;
   localparam logic [7:0] SC_NUM_UP    = 8'hC5;

   // cursor and keypad codes
   localparam logic [7:0] SC_HOME  = 8'd71;
   localparam logic [7:0] SC_UP    = 8'd72;
   localparam logic [7:0] SC_PGUP  = 8'd73;
   localparam logic [7:0] SC_LEFT  = 8'd75;
   localparam logic [7:0] SC_PAD5  = 8'd76;
   localparam logic [7:0] SC_RIGHT = 8'd77;
   localparam logic [7:0] SC_END   = 8'd79;
   localparam logic [7:0] SC_DOWN  = 8'd80;
   localparam logic [7:0] SC_PGDN  = 8'd81;
   localparam logic [7:0] SC_INS   = 8'd82;
   localparam logic [7:0] SC_DEL   = 8'd83;

   typedef enum logic {
      KIND_CHAR   = 1'b0,
      KIND_SCREEN = 1'b1
   } kind_type;

   // one decoded scan code: up to four result bytes
   typedef struct packed {
      kind_type                       kind;
      logic [IDX_W-1:0]               last_idx;
      logic [JOB_MAX-1:0][BYTE_W-1:0] bytes;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // unshifted key map, unmapped entries read as NOMAP
   function automatic logic [7:0] plain_lut(input logic [6:0] idx);
      logic [7:0] ch;
      case (idx)
         7'd0:  ch = 8'h00;  7'd1:  ch = 8'h1B;  7'd2:  ch = "1";    7'd3:  ch = "2";
         7'd4:  ch = "3";    7'd5:  ch = "4";    7'd6:  ch = "5";    7'd7:  ch = "6";
         7'd8:  ch = "7";    7'd9:  ch = "8";    7'd10: ch = "9";    7'd11: ch = "0";
         7'd12: ch = "-";    7'd13: ch = "=";    7'd14: ch = 8'h08;  7'd15: ch = 8'h09;
         7'd16: ch = "q";    7'd17: ch = "w";    7'd18: ch = "e";    7'd19: ch = "r";
         7'd20: ch = "t";    7'd21: ch = "y";    7'd22: ch = "u";    7'd23: ch = "i";
         7'd24: ch = "o";    7'd25: ch = "p";    7'd26: ch = "[";    7'd27: ch = "]";
         7'd28: ch = 8'h0D;  7'd30: ch = "a";    7'd31: ch = "s";    7'd32: ch = "d";
         7'd33: ch = "f";    7'd34: ch = "g";    7'd35: ch = "h";    7'd36: ch = "j";
         7'd37: ch = "k";    7'd38: ch = "l";    7'd39: ch = ";";    7'd40: ch = 8'h27;
         7'd41: ch = 8'h60;  7'd43: ch = 8'h5C;  7'd44: ch = "z";    7'd45: ch = "x";
         7'd46: ch = "c";    7'd47: ch = "v";    7'd48: ch = "b";    7'd49: ch = "n";
         7'd50: ch = "m";    7'd51: ch = ",";    7'd52: ch = ".";    7'd53: ch = "/";
         7'd55: ch = "*";    7'd57: ch = " ";    7'd82: ch = "0";    7'd83: ch = 8'h7F;
         default: ch = NOMAP;
      endcase
      return ch;
   endfunction

   // shifted key map, also gives the keypad digits
   function automatic logic [7:0] shift_lut(input logic [6:0] idx);
      logic [7:0] ch;
      case (idx)
         7'd0:  ch = 8'h00;  7'd1:  ch = 8'h1B;  7'd2:  ch = "!";    7'd3:  ch = "@";
         7'd4:  ch = "#";    7'd5:  ch = "$";    7'd6:  ch = "%";    7'd7:  ch = "^";
         7'd8:  ch = "&";    7'd9:  ch = "*";    7'd10: ch = "(";    7'd11: ch = ")";
         7'd12: ch = "_";    7'd13: ch = "+";    7'd14: ch = 8'h08;  7'd15: ch = 8'h09;
         7'd16: ch = "Q";    7'd17: ch = "W";    7'd18: ch = "E";    7'd19: ch = "R";
         7'd20: ch = "T";    7'd21: ch = "Y";    7'd22: ch = "U";    7'd23: ch = "I";
         7'd24: ch = "O";    7'd25: ch = "P";    7'd26: ch = "{";    7'd27: ch = "}";
         7'd28: ch = 8'h0D;  7'd30: ch = "A";    7'd31: ch = "S";    7'd32: ch = "D";
         7'd33: ch = "F";    7'd34: ch = "G";    7'd35: ch = "H";    7'd36: ch = "J";
         7'd37: ch = "K";    7'd38: ch = "L";    7'd39: ch = ":";    7'd40: ch = 8'h22;
         7'd41: ch = "~";    7'd43: ch = "|";    7'd44: ch = "Z";    7'd45: ch = "X";
         7'd46: ch = "C";    7'd47: ch = "V";    7'd48: ch = "B";    7'd49: ch = "N";
         7'd50: ch = "M";    7'd51: ch = "<";    7'd52: ch = ">";    7'd53: ch = "?";
         7'd55: ch = "*";    7'd57: ch = " ";    7'd71: ch = "7";    7'd72: ch = "8";
         7'd73: ch = "9";    7'd75: ch = "4";    7'd76: ch = "5";    7'd77: ch = "6";
         7'd79: ch = "1";    7'd80: ch = "2";    7'd81: ch = "3";    7'd82: ch = "0";
         7'd83: ch = 8'h7F;
         default: ch = NOMAP;
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/core/sct_front.sv
module sct_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      code,
   output logic            push,
   output sct_pkg::job_type push_job
);
   import sct_pkg::*;

   logic shift_ff, alt_ff, ctrl_ff, caps_ff, num_ff, ext_ff;
   logic shift_in, alt_in, ctrl_in, caps_in, num_in, ext_in;
   logic       has_job;
   job_type    job;
   job_type    esc_job;
   logic       cursor_hit;
   logic       esc_valid;
   logic       numeric;
   logic       is_mod;
   logic [7:0] pl_ch;
   logic [7:0] sh_ch;
   logic [7:0] ch;
   logic       letter;

   function automatic job_type make_job(input logic [IDX_W-1:0] last_idx,
                                        input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
      job_type j;
      j.kind     = KIND_CHAR;
      j.last_idx = last_idx;
      j.bytes[0] = b0;
      j.bytes[1] = b1;
      j.bytes[2] = b2;
      j.bytes[3] = b3;
      return j;
   endfunction

   // table lookups and caps handling for ordinary keys
   always_comb begin
      pl_ch  = plain_lut(code[6:0]);
      sh_ch  = shift_lut(code[6:0]);
      letter = (pl_ch >= CH_LOW_A) && (pl_ch <= CH_LOW_Z);
      ch     = (shift_ff ^ (caps_ff & letter)) ? sh_ch : pl_ch;
   end

   // classify the scan code and work out the flags it leaves
   always_comb begin
      shift_in   = shift_ff;
      alt_in     = alt_ff;
      ctrl_in    = ctrl_ff;
      caps_in    = caps_ff;
      num_in     = num_ff;
      ext_in     = ext_ff;
      has_job    = 1'b0;
      job        = '0;
      esc_job    = '0;
      cursor_hit = 1'b0;
      esc_valid  = 1'b0;
      is_mod     = 1'b1;
      numeric    = !ext_ff && (num_ff ^ shift_ff);
      if (alt_ff && (code >= SC_F1) && (code <= SC_F10)) begin
         // screen select, prefix flag kept
         has_job      = 1'b1;
         job.kind     = KIND_SCREEN;
         job.bytes[0] = code - SC_F1;
      end else begin
         unique case (code) inside
            SC_RSHIFT, SC_LSHIFT:       shift_in = 1'b1;
            SC_RSHIFT_UP, SC_LSHIFT_UP: shift_in = 1'b0;
            PREFIX_E0:                  ext_in   = 1'b1;
            SC_CTRL:                    ctrl_in  = 1'b1;
            SC_CTRL_UP:                 ctrl_in  = 1'b0;
            SC_ALT:                     alt_in   = 1'b1;
            SC_ALT_UP:                  alt_in   = 1'b0;
            SC_CAPS, SC_NUM:            is_mod   = 1'b1;
            SC_CAPS_UP:                 caps_in  = ~caps_ff;
            SC_NUM_UP:                  num_in   = ~num_ff;
            default:                    is_mod   = 1'b0;
         endcase
         if (!is_mod && !code[7]) begin
            unique case (code) inside
               SC_UP: begin
                  cursor_hit = 1'b1;
                  esc_valid  = 1'b1;
                  esc_job    = make_job(2'd2, CH_ESC, CH_O, "A", 8'h00);
               end
               SC_DOWN: begin
                  cursor_hit = 1'b1;
                  esc_valid  = 1'b1;
                  esc_job    = make_job(2'd2, CH_ESC, CH_O, "B", 8'h00);
               end
               SC_RIGHT: begin
                  cursor_hit = 1'b1;
                  esc_valid  = 1'b1;
                  esc_job    = make_job(2'd2, CH_ESC, CH_O, "C", 8'h00);
               end
               SC_LEFT: begin
                  cursor_hit = 1'b1;
                  esc_valid  = 1'b1;
                  esc_job    = make_job(2'd2, CH_ESC, CH_O, "D", 8'h00);
               end
               SC_PGUP: begin
                  cursor_hit = 1'b1;
                  esc_valid  = 1'b1;
                  esc_job    = make_job(2'd3, CH_ESC, CH_LBRK, "5", CH_TILDE);
               end
               SC_PGDN: begin
                  cursor_hit = 1'b1;
                  esc_valid  = 1'b1;
                  esc_job    = make_job(2'd3, CH_ESC, CH_LBRK, "6", CH_TILDE);
               end
               SC_INS: begin
                  cursor_hit = 1'b1;
                  esc_valid  = 1'b1;
                  esc_job    = make_job(2'd3, CH_ESC, CH_LBRK, "2", CH_TILDE);
               end
               SC_DEL: begin
                  cursor_hit = 1'b1;
                  esc_valid  = 1'b1;
                  esc_job    = make_job(2'd3, CH_ESC, CH_LBRK, "3", CH_TILDE);
               end
               SC_HOME, SC_PAD5, SC_END: begin
                  cursor_hit = 1'b1;
               end
               [SC_F1:SC_F9]: begin
                  has_job = 1'b1;
                  job     = make_job(2'd2, CH_ESC, CH_O, code + FKEY_TO_CH, 8'h00);
               end
               SC_F10, SC_F11, SC_F12: begin
                  has_job = 1'b0;
               end
               default: begin
                  // unmapped keys are dropped before the control mask
                  if ((code < TBL_LEN) && (ch != NOMAP)) begin
                     has_job = 1'b1;
                     job     = make_job(2'd0, ctrl_ff ? (ch & CTL_MASK) : ch,
                                        8'h00, 8'h00, 8'h00);
                  end
               end
            endcase
            // keypad digit or escape string
            if (cursor_hit) begin
               if (numeric) begin
                  has_job = 1'b1;
                  job     = make_job(2'd0, sh_ch, 8'h00, 8'h00, 8'h00);
               end else if (esc_valid) begin
                  has_job = 1'b1;
                  job     = esc_job;
               end
            end
         end
         ext_in = (code == PREFIX_E0);
      end
   end

   // modifier flags
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         alt_ff   <= 1'b0;
         ctrl_ff  <= 1'b0;
         caps_ff  <= 1'b0;
         num_ff   <= 1'b0;
         ext_ff   <= 1'b0;
      end else if (accept) begin
         shift_ff <= shift_in;
         alt_ff   <= alt_in;
         ctrl_ff  <= ctrl_in;
         caps_ff  <= caps_in;
         num_ff   <= num_in;
         ext_ff   <= ext_in;
      end
   end

   assign push     = accept && has_job;
   assign push_job = job;

endmodule

>>> rtl/core/sct_queue.sv
module sct_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sct_pkg::job_type      push_job,
   input  logic                  pop,
   output sct_pkg::job_type      head,
   output sct_pkg::q_status_type status
);
   import sct_pkg::*;

   job_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (Q_PTR_W + 1)'(Q_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> rtl/core/sct_back.sv
module sct_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sct_pkg::job_type      head,
   input  sct_pkg::q_status_type status,
   output logic                  pop,
   input  logic                  out_ready,
   output logic                  out_valid,
   output sct_pkg::kind_type     out_kind,
   output logic [7:0]            out_value,
   output logic                  out_last
);
   import sct_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   kind_type         kind_ff;
   logic [7:0]       value_ff;
   logic             last_ff;
   logic             load;
   logic             at_end;

   // next byte enters the output register when it is free or being taken
   always_comb begin
      load     = !status.empty && (!valid_ff || out_ready);
      at_end   = (idx_ff == head.last_idx);
      pop      = load && at_end;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = at_end ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= head.kind;
         value_ff <= head.bytes[idx_ff];
         last_ff  <= at_end;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_value = value_ff;
   assign out_last  = last_ff;

endmodule

>>> rtl/core/scan_code_to_ascii_translator.sv
// a decoded scan code is written into the job queue; its bytes then leave through the output register
// throughput: one result byte per cycle from the output register while the receiver is ready, 0 to 4 per scan code
// a scan code is taken every cycle while the two-job queue between decoder and
// serializer has room; codes that give no result never occupy the queue
// reset: synchronous, active high; clears all modifier flags, the queue and the output
module scan_code_to_ascii_translator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] value
   output logic       rsp_tuser,   // [0] kind
   output logic       rsp_tlast
);
   import sct_pkg::*;

   logic         accept;
   logic         push;
   job_type      push_job;
   job_type      head;
   logic         pop;
   q_status_type status;
   kind_type     out_kind;

   // input transfer
   assign req_tready = !status.full;
   assign accept     = req_tvalid && req_tready;

   sct_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .code     (req_tdata),
      .push     (push),
      .push_job (push_job)
   );

   sct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (status)
   );

   sct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_kind  (out_kind),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = out_kind;

endmodule

>>> rtl/core/sct_checker.sv
`include "assert_macros.svh"

module sct_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);
   import sct_pkg::*;

   logic       rsp_stall;
   logic       rsp_screen;
   logic [9:0] rsp_payload;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_screen  = rsp_tvalid && (rsp_tuser == KIND_SCREEN);
   assign rsp_payload = {rsp_tlast, rsp_tuser, rsp_tdata};

   // a stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid, "rsp dropped while stalled")

   // a stalled result keeps its payload
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_payload), "rsp payload moved")

   // a screen select is always the only result of its scan code
   `ASSERT_CLK(a_screen_last, clock, reset, rsp_screen |-> rsp_tlast, "screen select without tlast")

   // screen numbers stay in 0..9
   `ASSERT_CLK(a_screen_range, clock, reset, rsp_screen |-> rsp_tdata <= 8'd9, "bad screen number")

   // nothing is offered right after reset
   `ASSERT_CLK_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")

endmodule

bind scan_code_to_ascii_translator sct_checker u_sct_checker (.*);

>>> sim/scan_code_translation_check.sv
// watches both channels, predicts the key translation and compares each rsp transfer
module scan_code_translation_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_code
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] value
   input  logic       rsp_tuser,   // [0] kind
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         expected_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import sct_pkg::*;

   localparam int       KEY_MAP_LEN = 84;
   localparam int       REPORT_MAX  = 10;
   localparam logic [7:0] CH_P      = "P";

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       last;
   } key_result_type;

   key_result_type key_result_q[$];
   key_result_type burst_q[$];

   logic [7:0] plain_map [0:KEY_MAP_LEN-1];
   logic [7:0] shift_map [0:KEY_MAP_LEN-1];

   // modifier and lock flags
   logic shift_held;
   logic alt_held;
   logic ctrl_held;
   logic caps_on;
   logic num_on;
   logic e0_seen;

   function automatic void put_keys(input int base, input string lower, input string upper);
      for (int i = 0; i < lower.len(); i++) begin
         plain_map[base+i] = lower[i];
         shift_map[base+i] = upper[i];
      end
   endfunction

   // key maps, unmapped entries hold the no-map marker
   initial begin
      for (int i = 0; i < KEY_MAP_LEN; i++) begin
         plain_map[i] = NOMAP;
         shift_map[i] = NOMAP;
      end
      put_keys(2, "1234567890-=", "!@#$%^&*()_+");
      put_keys(16, "qwertyuiop[]", "QWERTYUIOP{}");
      put_keys(30, "asdfghjkl;'", "ASDFGHJKL:\"");
      put_keys(43, "\\zxcvbnm,./", "|ZXCVBNM<>?");
      put_keys(55, "*", "*");
      put_keys(57, " ", " ");
      plain_map[0]  = 8'h00;  shift_map[0]  = 8'h00;
      plain_map[1]  = 8'h1B;  shift_map[1]  = 8'h1B;
      plain_map[14] = 8'h08;  shift_map[14] = 8'h08;
      plain_map[15] = 8'h09;  shift_map[15] = 8'h09;
      plain_map[28] = 8'h0D;  shift_map[28] = 8'h0D;
      plain_map[41] = 8'h60;  shift_map[41] = "~";
      plain_map[82] = "0";    shift_map[82] = "0";
      plain_map[83] = 8'h7F;  shift_map[83] = 8'h7F;
      // keypad digits 1 to 9 live in the shifted map only
      shift_map[71] = "7";  shift_map[72] = "8";  shift_map[73] = "9";
      shift_map[75] = "4";  shift_map[76] = "5";  shift_map[77] = "6";
      shift_map[79] = "1";  shift_map[80] = "2";  shift_map[81] = "3";
   end

   function automatic void add_byte(input logic [7:0] b);
      key_result_type r;
      r.kind  = KIND_CHAR;
      r.value = b;
      r.last  = 1'b0;
      burst_q.push_back(r);
   endfunction

   // cursor keys: keypad digit in numeric mode, else an escape sequence
   function automatic void cursor_bytes(input logic numeric, input logic [7:0] code,
                                        input string tail);
      if (numeric) begin
         add_byte(shift_map[code]);
      end else begin
         add_byte(CH_ESC);
         for (int i = 0; i < tail.len(); i++) add_byte(tail[i]);
      end
   endfunction

   // advance the flags for one scan code and queue the bytes it produces
   function automatic void translate(input logic [7:0] code);
      logic       was_mod;
      logic       numeric;
      logic [7:0] ch;
      key_result_type r;
      burst_q.delete();
      // alt plus F1..F10 selects a screen, prefix flag untouched
      if (alt_held && code >= SC_F1 && code <= SC_F10) begin
         r.kind  = KIND_SCREEN;
         r.value = code - SC_F1;
         r.last  = 1'b1;
         key_result_q.push_back(r);
         return;
      end
      was_mod = 1'b1;
      case (code)
         SC_RSHIFT, SC_LSHIFT:       shift_held = 1'b1;
         SC_RSHIFT_UP, SC_LSHIFT_UP: shift_held = 1'b0;
         PREFIX_E0:                  e0_seen = 1'b1;
         SC_CTRL:                    ctrl_held = 1'b1;
         SC_CTRL_UP:                 ctrl_held = 1'b0;
         SC_ALT:                     alt_held = 1'b1;
         SC_ALT_UP:                  alt_held = 1'b0;
         SC_CAPS, SC_NUM:            ;
         SC_CAPS_UP:                 caps_on = ~caps_on;
         SC_NUM_UP:                  num_on = ~num_on;
         default:                    was_mod = 1'b0;
      endcase
      if (!was_mod && !code[7]) begin
         numeric = !e0_seen && (num_on ^ shift_held);
         case (code)
            SC_UP:    cursor_bytes(numeric, code, "OA");
            SC_DOWN:  cursor_bytes(numeric, code, "OB");
            SC_RIGHT: cursor_bytes(numeric, code, "OC");
            SC_LEFT:  cursor_bytes(numeric, code, "OD");
            SC_PGUP:  cursor_bytes(numeric, code, "[5~");
            SC_PGDN:  cursor_bytes(numeric, code, "[6~");
            SC_INS:   cursor_bytes(numeric, code, "[2~");
            SC_DEL:   cursor_bytes(numeric, code, "[3~");
            SC_HOME, SC_PAD5, SC_END: begin
               if (numeric) add_byte(shift_map[code]);
            end
            SC_F10, SC_F11, SC_F12: ;
            default: begin
               if (code >= SC_F1 && code <= SC_F9) begin
                  add_byte(CH_ESC);
                  add_byte(CH_O);
                  add_byte(CH_P + (code - SC_F1));
               end else if (code < KEY_MAP_LEN) begin
                  // caps only swaps case on letter keys
                  if (caps_on && plain_map[code] >= CH_LOW_A && plain_map[code] <= CH_LOW_Z)
                     ch = shift_held ? plain_map[code] : shift_map[code];
                  else
                     ch = shift_held ? shift_map[code] : plain_map[code];
                  if (ch != NOMAP) begin
                     if (ctrl_held) ch = ch & CTL_MASK;
                     add_byte(ch);
                  end
               end
            end
         endcase
      end
      if (code != PREFIX_E0) e0_seen = 1'b0;
      if (burst_q.size() > 0) begin
         burst_q[burst_q.size()-1].last = 1'b1;
         foreach (burst_q[i]) key_result_q.push_back(burst_q[i]);
      end
   endfunction

   function automatic void report(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("%s", msg);
   endfunction

   // compare rsp transfers first, then predict from the req transfer of the same edge
   always @(posedge clock) begin
      key_result_type want;
      if (reset) begin
         key_result_q.delete();
         shift_held = 1'b0;
         alt_held   = 1'b0;
         ctrl_held  = 1'b0;
         caps_on    = 1'b0;
         num_on     = 1'b0;
         e0_seen    = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (key_result_q.size() == 0) begin
               report($sformatf("unexpected rsp transfer: kind=%0d value=%02h last=%0d",
                                rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               want = key_result_q.pop_front();
               if (want.kind != rsp_tuser || want.value != rsp_tdata ||
                   want.last != rsp_tlast)
                  report($sformatf({"rsp transfer wrong: expected kind=%0d value=%02h ",
                                    "last=%0d, got kind=%0d value=%02h last=%0d"},
                                   want.kind, want.value, want.last,
                                   rsp_tuser, rsp_tdata, rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) translate(req_tdata);
      end
      expected_count <= key_result_q.size();
   end

endmodule

>>> sim/tb_scan_code_to_ascii_translator.sv
module tb_scan_code_to_ascii_translator;

   timeunit 1ns;
   timeprecision 1ps;

   import sct_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 400;
   localparam int IDLE_PCT     = 16;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] scan_code
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] value
   logic       rsp_tuser;           // [0] kind
   logic       rsp_tlast;

   logic        no_idle = 1'b0;
   int          fail_count;
   int          expected_count;
   int unsigned cycle_count = 0;

   // directed opening: table ends, every key class, locks, prefix, alt screens
   logic [7:0] directed_codes [$] = '{
      8'h00, 8'h1E, SC_LSHIFT, 8'h35, SC_LSHIFT_UP, SC_CAPS, SC_CAPS_UP, 8'h1E,
      SC_CTRL, 8'h1E, SC_CTRL_UP, SC_UP, SC_PGUP, SC_NUM, SC_NUM_UP, SC_HOME,
      SC_PAD5, SC_DEL, PREFIX_E0, SC_UP, SC_ALT, SC_F1, SC_F10, SC_ALT_UP,
      SC_F1, SC_F10, SC_F12, 8'h54, 8'hFF, 8'h4A
   };

   logic [7:0] modifier_codes [$] = '{
      SC_LSHIFT, SC_RSHIFT, SC_LSHIFT_UP, SC_RSHIFT_UP, SC_CTRL, SC_CTRL_UP,
      SC_ALT, SC_ALT_UP, SC_CAPS, SC_NUM, SC_CAPS_UP, SC_NUM_UP
   };

   always #5 clock = ~clock;

   scan_code_to_ascii_translator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   scan_code_translation_check translation_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .expected_count (expected_count)
   );

   // receiver stalls at random outside the quiet stretch
   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("scan_code_to_ascii_translator: mismatch");
         $finish;
      end
   end

   // one scan code transfer, with random gaps ahead of it
   task automatic send_code(input logic [7:0] code);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(0, 255));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off the sender until every expected result has come
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
   endtask

   initial begin
      int         sel;
      logic [7:0] code;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_codes[i]) send_code(directed_codes[i]);
      wait_drained();

      // mostly real key traffic, some releases, prefixes and noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 150 && n < 250);
         if (n == 300) wait_drained();
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            code = 8'($urandom_range(0, 83));
         end else if (sel < 48) begin
            code = 8'($urandom_range(SC_HOME, SC_DEL));
         end else if (sel < 60) begin
            code = modifier_codes[$urandom_range(0, modifier_codes.size() - 1)];
         end else if (sel < 67) begin
            // extended prefix followed by a cursor key
            send_code(PREFIX_E0);
            code = 8'($urandom_range(SC_HOME, SC_DEL));
         end else if (sel < 75) begin
            code = ($urandom_range(0, 5) == 0) ? SC_F11 + 8'($urandom_range(0, 1))
                                               : 8'($urandom_range(SC_F1, SC_F10));
         end else if (sel < 85) begin
            code = 8'h80 | 8'($urandom_range(0, 127));
         end else if (sel < 89) begin
            code = 8'($urandom_range(84, 127));
         end else begin
            code = 8'($urandom_range(0, 255));
         end
         send_code(code);
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_count == 0)
         $display("scan_code_to_ascii_translator: match");
      else
         $display("scan_code_to_ascii_translator: mismatch");
      $finish;
   end

endmodule
